@@ design/prspmv_pkg.sv @@
`default_nettype none

package prspmv_pkg;

  // Sizes
  localparam int MAX_ROWS = 4096;
  localparam int ADDR_W   = $clog2(MAX_ROWS);
  localparam int NROWS_W  = ADDR_W + 1;
  localparam int ACC_W    = 40;
  localparam int MEM_W    = ACC_W + 1;   // accumulator plus written flag on top
  localparam int DATA_W   = 32;
  localparam int FRAC_W   = 24;
  localparam int INV_W    = 32;
  localparam int MUL_W    = DATA_W + 1;
  localparam int PROD_W   = 2 * DATA_W;
  localparam int RND24_W  = PROD_W + 1 - FRAC_W;
  localparam int RND32_W  = PROD_W + 1 - INV_W;
  localparam int WIDE_W   = ((ACC_W > RND24_W) ? ACC_W : RND24_W) + 2;
  localparam int CFG_AW   = 4;

  // Saturation limits, extended to the working width
  localparam logic signed [WIDE_W-1:0] ACC_MAX_W =
    {{(WIDE_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] ACC_MIN_W =
    {{(WIDE_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};
  localparam logic signed [WIDE_W-1:0] DAT_MAX_W =
    {{(WIDE_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] DAT_MIN_W =
    {{(WIDE_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

  // Register map (word index)
  localparam logic [1:0] REG_N_ROWS = 2'd0;
  localparam logic [1:0] REG_EMPTY  = 2'd1;
  localparam logic [1:0] REG_INV    = 2'd2;

  localparam logic [NROWS_W-1:0] N_ROWS_RST = NROWS_W'(MAX_ROWS);
  localparam logic [INV_W-1:0]   INV_RST    = 32'd1048576;

  typedef enum logic [1:0] {
    REQ_CLEAR   = 2'd0,
    REQ_ROW     = 2'd1,
    REQ_NONZERO = 2'd2,
    REQ_READ    = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROW_MUL_A,
    ST_ROW_MUL_B,
    ST_ROW_DIFF,
    ST_ROW_ADD,
    ST_NZ_MUL,
    ST_NZ_RND,
    ST_NZ_WR,
    ST_RD
  } state_t;

  typedef struct packed {
    req_t                     req_type;
    logic signed [DATA_W-1:0] row_value;
    logic                     row_empty;
    logic [ADDR_W-1:0]        column;
    logic signed [DATA_W-1:0] matrix_value;
    logic [ADDR_W-1:0]        read_index;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic                     index_error;
  } out_item_t;

  typedef struct packed {
    logic [NROWS_W-1:0]       n_rows;
    logic signed [DATA_W-1:0] empty_value;
    logic [INV_W-1:0]         inv_rows;
  } cfg_regs_t;

endpackage

`default_nettype wire

@@ design/prspmv_ram.sv @@
`default_nettype none

module prspmv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ design/prspmv_cfg.sv @@
`default_nettype none

module prspmv_cfg import prspmv_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output      logic [31:0]       prdata,
  output      logic              pready,
  output      cfg_regs_t         cfg
);

  cfg_regs_t  cfg_r;
  cfg_regs_t  cfg_nxt;
  logic [1:0] reg_idx;
  logic       wr_xfer;

  assign reg_idx = paddr[CFG_AW-1:2];
  assign wr_xfer = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_xfer) begin
      case (reg_idx)
        REG_N_ROWS: cfg_nxt.n_rows      = pwdata[NROWS_W-1:0];
        REG_EMPTY:  cfg_nxt.empty_value = $signed(pwdata);
        REG_INV:    cfg_nxt.inv_rows    = pwdata[INV_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.n_rows      <= N_ROWS_RST;
      cfg_r.empty_value <= '0;
      cfg_r.inv_rows    <= INV_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_N_ROWS: prdata = 32'(cfg_r.n_rows);
      REG_EMPTY:  prdata = cfg_r.empty_value;
      REG_INV:    prdata = cfg_r.inv_rows;
      default:    prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ design/prspmv_core.sv @@
`default_nettype none

module prspmv_core import prspmv_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_regs_t         cfg,
  input  wire logic              start,
  input  wire in_item_t          in_payload,
  output      logic              busy,
  output      logic              out_valid,
  output      out_item_t         out_payload,
  output      logic              mem_we,
  output      logic [ADDR_W-1:0] mem_waddr,
  output      logic [MEM_W-1:0]  mem_wdata,
  output      logic              mem_re,
  output      logic [ADDR_W-1:0] mem_raddr,
  input  wire logic [MEM_W-1:0]  mem_rdata
);

  localparam logic [ADDR_W-1:0] SWEEP_LAST = ADDR_W'(MAX_ROWS - 1);
  localparam logic signed [PROD_W:0] HALF24 = (PROD_W+1)'(1) <<< (FRAC_W - 1);
  localparam logic signed [PROD_W:0] HALF32 = (PROD_W+1)'(1) <<< (INV_W - 1);

  // Round to nearest, ties up, dropping 24 fraction bits
  function automatic logic signed [RND24_W-1:0] rnd24(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W:0] t;
    t = (PROD_W+1)'(x) + HALF24;
    return t[PROD_W:FRAC_W];
  endfunction

  // Round to nearest, ties up, dropping 32 fraction bits
  function automatic logic signed [RND32_W-1:0] rnd32(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W:0] t;
    t = (PROD_W+1)'(x) + HALF32;
    return t[PROD_W:INV_W];
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] r;
    if (x > ACC_MAX_W) r = ACC_MAX_W;
    else if (x < ACC_MIN_W) r = ACC_MIN_W;
    else r = x;
    return r[ACC_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_dat(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] r;
    if (x > DAT_MAX_W) r = DAT_MAX_W;
    else if (x < DAT_MIN_W) r = DAT_MIN_W;
    else r = x;
    return r[DATA_W-1:0];
  endfunction

  state_t                    state_r, state_nxt;
  logic [ADDR_W-1:0]         sweep_r, sweep_nxt;
  in_item_t                  item_r, item_nxt;
  logic signed [DATA_W-1:0]  crv_r, crv_nxt;
  logic signed [ACC_W-1:0]   dang_r, dang_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [RND32_W-1:0] a_r, a_nxt;
  logic signed [ACC_W-1:0]   d_r, d_nxt;
  logic signed [ACC_W-1:0]   p_r, p_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_item_r, out_item_nxt;

  logic                      accept;
  logic                      col_err;
  logic                      rd_err;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;
  logic signed [RND24_W-1:0] b_w;
  logic signed [ACC_W-1:0]   base_w;
  logic signed [ACC_W-1:0]   acc_sum;
  logic signed [DATA_W-1:0]  rd_val;

  // Control decodes
  logic ld_prod, ld_a, ld_d, add_dang, ld_p, wr_acc, sweep_on, rd_out;

  assign accept  = start && (state_r == ST_IDLE);
  assign col_err = {1'b0, in_payload.column} >= cfg.n_rows;
  assign rd_err  = {1'b0, in_payload.read_index} >= cfg.n_rows;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:     if (sweep_r == SWEEP_LAST) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (start) begin
          case (in_payload.req_type)
            REQ_CLEAR:   state_nxt = ST_CLEAR;
            REQ_ROW:     state_nxt = in_payload.row_empty ? ST_ROW_MUL_A : ST_IDLE;
            REQ_NONZERO: state_nxt = col_err ? ST_IDLE : ST_NZ_MUL;
            REQ_READ:    state_nxt = rd_err ? ST_IDLE : ST_RD;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ROW_MUL_A: state_nxt = ST_ROW_MUL_B;
      ST_ROW_MUL_B: state_nxt = ST_ROW_DIFF;
      ST_ROW_DIFF:  state_nxt = ST_ROW_ADD;
      ST_ROW_ADD:   state_nxt = ST_IDLE;
      ST_NZ_MUL:    state_nxt = ST_NZ_RND;
      ST_NZ_RND:    state_nxt = ST_NZ_WR;
      ST_NZ_WR:     state_nxt = ST_IDLE;
      ST_RD:        state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    busy     = 1'b1;
    ld_prod  = 1'b0;
    ld_a     = 1'b0;
    ld_d     = 1'b0;
    add_dang = 1'b0;
    ld_p     = 1'b0;
    wr_acc   = 1'b0;
    sweep_on = 1'b0;
    rd_out   = 1'b0;
    case (state_r)
      ST_CLEAR:     sweep_on = 1'b1;
      ST_IDLE:      busy     = 1'b0;
      ST_ROW_MUL_A: ld_prod  = 1'b1;
      ST_ROW_MUL_B: begin
        ld_prod = 1'b1;
        ld_a    = 1'b1;
      end
      ST_ROW_DIFF:  ld_d     = 1'b1;
      ST_ROW_ADD:   add_dang = 1'b1;
      ST_NZ_MUL:    ld_prod  = 1'b1;
      ST_NZ_RND:    ld_p     = 1'b1;
      ST_NZ_WR:     wr_acc   = 1'b1;
      ST_RD:        rd_out   = 1'b1;
      default:      busy     = 1'b1;
    endcase
  end

  // Shared multiplier: row value times inv_rows, empty_value or matrix value
  always_comb begin
    mul_a = MUL_W'(crv_r);
    case (state_r)
      ST_ROW_MUL_A: mul_b = $signed({1'b0, cfg.inv_rows});
      ST_ROW_MUL_B: mul_b = MUL_W'(cfg.empty_value);
      default:      mul_b = MUL_W'(item_r.matrix_value);
    endcase
    mul_p = mul_a * mul_b;
  end

  // Accumulator base: unwritten entries read as the teleport value
  always_comb begin
    if (mem_rdata[ACC_W]) base_w = $signed(mem_rdata[ACC_W-1:0]);
    else base_w = ACC_W'(cfg.empty_value);
  end

  assign b_w     = rnd24(prod_r);
  assign acc_sum = sat_acc(WIDE_W'(base_w) + WIDE_W'(p_r));
  assign rd_val  = sat_dat(WIDE_W'(base_w) + WIDE_W'(dang_r));

  // Memory port: read at accept, write during the sweep or write-back
  always_comb begin
    mem_re    = accept;
    mem_raddr = (in_payload.req_type == REQ_READ) ? in_payload.read_index
                                                  : in_payload.column;
    mem_we    = sweep_on || wr_acc;
    mem_waddr = sweep_on ? sweep_r : item_r.column;
    mem_wdata = sweep_on ? '0 : {1'b1, acc_sum};
  end

  // Datapath next values
  always_comb begin
    sweep_nxt     = sweep_r;
    item_nxt      = item_r;
    crv_nxt       = crv_r;
    dang_nxt      = dang_r;
    prod_nxt      = prod_r;
    a_nxt         = a_r;
    d_nxt         = d_r;
    p_nxt         = p_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;

    if (sweep_on) sweep_nxt = sweep_r + 1'b1;
    if (ld_prod)  prod_nxt  = mul_p[PROD_W-1:0];
    if (ld_a)     a_nxt     = rnd32(prod_r);
    if (ld_d)     d_nxt     = sat_acc(WIDE_W'(a_r) - WIDE_W'(b_w));
    if (add_dang) dang_nxt  = sat_acc(WIDE_W'(dang_r) + WIDE_W'(d_r));
    if (ld_p)     p_nxt     = sat_acc(WIDE_W'(b_w));

    if (rd_out) begin
      out_valid_nxt             = 1'b1;
      out_item_nxt.result_value = rd_val;
      out_item_nxt.index_error  = 1'b0;
    end

    if (accept) begin
      item_nxt = in_payload;
      case (in_payload.req_type)
        REQ_CLEAR: begin
          sweep_nxt = '0;
          dang_nxt  = '0;
        end
        REQ_ROW:     crv_nxt = in_payload.row_value;
        REQ_NONZERO: begin
          if (col_err) begin
            out_valid_nxt             = 1'b1;
            out_item_nxt.result_value = '0;
            out_item_nxt.index_error  = 1'b1;
          end
        end
        REQ_READ: begin
          if (rd_err) begin
            out_valid_nxt             = 1'b1;
            out_item_nxt.result_value = '0;
            out_item_nxt.index_error  = 1'b1;
          end
        end
        default: item_nxt = in_payload;
      endcase
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      sweep_r     <= '0;
      crv_r       <= '0;
      dang_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      crv_r       <= crv_nxt;
      dang_r      <= dang_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    prod_r     <= prod_nxt;
    a_r        <= a_nxt;
    d_r        <= d_nxt;
    p_r        <= p_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_item_r;

endmodule

`default_nettype wire

@@ design/pagerank_sparse_scatter_spmv.sv @@
// PageRank scatter step over a sparse matrix in compressed row form.
// Input: an item is transferred on a rising edge with start high and busy low.
// Item kinds: clear, row start, nonzero entry, read. Results leave on out_payload
// for exactly one cycle, flagged by out_valid; the receiver cannot stall them,
// so results are never held back or dropped.
// Work per item, from the transfer edge until the next item can go:
//   row start, nonempty row ...... row value stored, no further work
//   row start, empty row ......... shared multiplier used twice, then difference and add
//   nonzero entry ................ read, multiply, round, write back
//   read ......................... read, then out_valid with the result
//   out-of-range index ........... no further work; error result in the next cycle
//   clear ........................ one accumulator entry per cycle
// The accumulators sit in one 4096-entry memory, read at transfer and
// written back in place; one item in flight at a time keeps accesses apart.
// Reset runs the same clearing pass over all entries with busy high; the APB
// registers take transfers at all times but are to be written only while idle.
`default_nettype none

module pagerank_sparse_scatter_spmv import prspmv_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output      logic [31:0]       prdata,
  output      logic              pready,
  input  wire logic              start,
  input  wire in_item_t          in_payload,
  output      logic              busy,
  output      logic              out_valid,
  output      out_item_t         out_payload
);

  cfg_regs_t         cfg;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [MEM_W-1:0]  mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [MEM_W-1:0]  mem_rdata;

  prspmv_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  prspmv_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .start       (start),
    .in_payload  (in_payload),
    .busy        (busy),
    .out_valid   (out_valid),
    .out_payload (out_payload),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  // Accumulator store with written flag
  prspmv_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_ROWS)
  ) u_acc_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

@@ design/prspmv_chk.sv @@
`default_nettype none

module prspmv_chk import prspmv_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire in_item_t          in_payload,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire out_item_t         out_payload
);

  logic xfer;
  assign xfer = start && !busy;

  // Reset starts the clearing pass
  ap_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  // A clear transfer starts a sweep
  ap_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && (in_payload.req_type == REQ_CLEAR) |=> busy)
    else $error("clear did not start the sweep");

  // Clear and row start never give a result
  ap_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && ((in_payload.req_type == REQ_CLEAR) || (in_payload.req_type == REQ_ROW))
    |=> !out_valid)
    else $error("result after clear or row start");

  // A result follows a transfer or work in progress
  ap_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(xfer) || $past(busy)))
    else $error("result with no item in progress");

  // Index errors carry a zero value
  ap_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.index_error |-> (out_payload.result_value == '0))
    else $error("index error with nonzero value");

endmodule

bind pagerank_sparse_scatter_spmv prspmv_chk u_chk (.*);

`default_nettype wire

@@ sim/pagerank_sparse_scatter_spmv_tb.sv @@
`timescale 1ns / 100ps

module pagerank_sparse_scatter_spmv_tb;
  import prspmv_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SHOW_MAX    = 40;

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [CFG_AW-1:0] paddr     = '0;
  logic [31:0]       pwdata    = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              start     = 1'b0;
  in_item_t          in_payload = '0;
  logic              busy;
  logic              out_valid;
  out_item_t         out_payload;

  pagerank_sparse_scatter_spmv dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .start      (start),
    .in_payload (in_payload),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_payload(out_payload)
  );

  // Shadow of the block: scatter accumulators, dangling sum, registers
  longint             acc_mem [MAX_ROWS];
  bit                 acc_written [MAX_ROWS];
  longint             row_val;
  longint             dangle;
  logic [NROWS_W-1:0] cfg_n_rows;
  longint             cfg_empty;
  logic [INV_W-1:0]   cfg_inv;

  in_item_t  req_q[$];
  out_item_t read_results_q[$];
  int        idle_pct = 0;
  bit        settle   = 1'b0;
  int        errors   = 0;
  int        cycles   = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (errors < SHOW_MAX)
      $display("mismatch at cycle %0d: %s, want %h got %h", cycles, what, want, got);
    errors++;
  endtask

  function automatic longint round_shift(input longint x, input int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(input longint x, input longint hi);
    if (x > hi) return hi;
    if (x < -hi - 1) return -hi - 1;
    return x;
  endfunction

  // Apply one accepted item to the shadow state, queue any result it causes
  task automatic scatter_apply(input in_item_t it);
    longint    hi, v, a, b, p, base, r;
    int        lim;
    out_item_t res;
    hi  = (longint'(1) <<< (ACC_W - 1)) - 1;
    lim = (cfg_n_rows < MAX_ROWS) ? int'(cfg_n_rows) : MAX_ROWS;
    res = '0;
    case (it.req_type)
      REQ_CLEAR: begin
        foreach (acc_written[i]) acc_written[i] = 1'b0;
        dangle = 0;
      end
      REQ_ROW: begin
        v       = longint'($signed(it.row_value));
        row_val = v;
        if (it.row_empty) begin
          a      = round_shift(v * longint'(cfg_inv), INV_W);
          b      = round_shift(v * cfg_empty, FRAC_W);
          dangle = clamp(dangle + clamp(a - b, hi), hi);
        end
      end
      REQ_NONZERO: begin
        if (int'(it.column) >= lim) begin
          res.index_error = 1'b1;
          read_results_q.push_back(res);
        end else begin
          p    = clamp(round_shift(row_val * longint'($signed(it.matrix_value)), FRAC_W), hi);
          base = acc_written[it.column] ? acc_mem[it.column] : clamp(cfg_empty, hi);
          acc_mem[it.column]     = clamp(base + p, hi);
          acc_written[it.column] = 1'b1;
        end
      end
      default: begin
        if (int'(it.read_index) >= lim) begin
          res.index_error = 1'b1;
        end else begin
          base = acc_written[it.read_index] ? acc_mem[it.read_index] : clamp(cfg_empty, hi);
          r    = clamp(clamp(base + dangle, hi), 64'sh7FFF_FFFF);
          res.result_value = r[31:0];
        end
        read_results_q.push_back(res);
      end
    endcase
  endtask

  // Driver: one transfer per start/!busy edge, random sender gaps
  always @(posedge clk) begin : drive_proc
    logic     nxt_start;
    in_item_t it;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      nxt_start = start;
      if (start && !busy) begin
        scatter_apply(in_payload);
        nxt_start = 1'b0;
        if ($urandom_range(15) == 0) settle = 1'b1;
      end
      // hold off until every pending result is back
      if (settle && read_results_q.size() == 0) settle = 1'b0;
      if (!nxt_start && req_q.size() != 0 && !settle &&
          $urandom_range(99) >= idle_pct) begin
        it         = req_q.pop_front();
        in_payload <= it;
        nxt_start  = 1'b1;
      end
      start <= nxt_start;
    end
  end

  // Monitor: results are strobed for one cycle
  always @(posedge clk) begin : check_proc
    out_item_t want;
    if (rst_n && out_valid) begin
      if (read_results_q.size() == 0) begin
        flag_mismatch("result with nothing pending", '0, out_payload.result_value);
      end else begin
        want = read_results_q.pop_front();
        if (out_payload.result_value !== want.result_value)
          flag_mismatch("result_value", want.result_value, out_payload.result_value);
        if (out_payload.index_error !== want.index_error)
          flag_mismatch("index_error", 32'(want.index_error), 32'(out_payload.index_error));
      end
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_N_ROWS: cfg_n_rows = val[NROWS_W-1:0];
      REG_EMPTY:  cfg_empty  = longint'($signed(val));
      default:    cfg_inv    = val;
    endcase
  endtask

  // Wait until nothing is queued or pending and the block has gone quiet
  task automatic wait_idle();
    @(negedge clk);
    while (req_q.size() != 0 || start || read_results_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_q824();
    case ($urandom_range(5))
      0, 1: return $urandom();
      2: return 32'($urandom_range(32'h0800_0000)) - 32'h0400_0000;
      3: begin
        case ($urandom_range(5))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'h0000_0001;
          4: return 32'hFFFF_FFFF;
          default: return 32'h0100_0000;
        endcase
      end
      default: return 32'($urandom_range(32'h0200_0000)) - 32'h0100_0000;
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] pick_index(input int span);
    int r;
    r = $urandom_range(9);
    if (r == 0) return ADDR_W'($urandom_range(MAX_ROWS - 1));
    if (r < 4) return ADDR_W'($urandom_range(((span < 8) ? span : 8) - 1));
    return ADDR_W'($urandom_range(span - 1));
  endfunction

  // Queue one item; fields the kind does not use get random filler
  task automatic put(input req_t k, input logic [31:0] val, input logic flag,
                     input logic [ADDR_W-1:0] idx);
    in_item_t it;
    it.req_type     = k;
    it.row_value    = $urandom();
    it.row_empty    = 1'($urandom_range(1));
    it.column       = ADDR_W'($urandom_range(MAX_ROWS - 1));
    it.matrix_value = $urandom();
    it.read_index   = ADDR_W'($urandom_range(MAX_ROWS - 1));
    case (k)
      REQ_ROW: begin
        it.row_value = val;
        it.row_empty = flag;
      end
      REQ_NONZERO: begin
        it.matrix_value = val;
        it.column       = idx;
      end
      REQ_READ: it.read_index = idx;
      default: ;
    endcase
    req_q.push_back(it);
  endtask

  // Mostly row blocks with their nonzeros and reads, some noise and clears
  task automatic queue_random(input int count);
    int made, span, pick, k;
    made = 0;
    if (cfg_n_rows == 0) span = MAX_ROWS;
    else span = (cfg_n_rows < MAX_ROWS) ? int'(cfg_n_rows) : MAX_ROWS;
    while (made < count) begin
      pick = $urandom_range(99);
      if (pick < 2) begin
        put(REQ_CLEAR, $urandom(), 1'b0, '0);
        made++;
      end else if (pick < 45) begin
        put(REQ_ROW, pick_q824(), ($urandom_range(9) < 3), '0);
        made++;
        k = $urandom_range(4);
        repeat (k) begin
          put(REQ_NONZERO, pick_q824(), 1'b0, pick_index(span));
          made++;
        end
      end else if (pick < 80) begin
        put(REQ_READ, $urandom(), 1'b0, pick_index(span));
        made++;
      end else begin
        put(req_t'($urandom_range(3, 1)), $urandom(), 1'($urandom_range(1)),
            ADDR_W'($urandom_range(MAX_ROWS - 1)));
        made++;
      end
    end
  endtask

  // New register setting, edge-of-range indices, then random traffic
  task automatic run_phase(input logic [31:0] n, input logic [31:0] emp,
                           input logic [31:0] inv, input int idle, input int count);
    logic [ADDR_W-1:0] edge_idx;
    wait_idle();
    cfg_write(REG_N_ROWS, n);
    cfg_write(REG_EMPTY, emp);
    cfg_write(REG_INV, inv);
    @(negedge clk);
    idle_pct = idle;
    edge_idx = (n >= MAX_ROWS) ? ADDR_W'(MAX_ROWS - 1) : ADDR_W'(n);
    put(REQ_NONZERO, pick_q824(), 1'b0, edge_idx);
    put(REQ_READ, $urandom(), 1'b0, edge_idx);
    put(REQ_READ, $urandom(), 1'b0, '0);
    queue_random(count);
  endtask

  initial begin
    foreach (acc_mem[i]) acc_mem[i] = 0;
    foreach (acc_written[i]) acc_written[i] = 1'b0;
    row_val    = 0;
    dangle     = 0;
    cfg_n_rows = N_ROWS_RST;
    cfg_empty  = 0;
    cfg_inv    = INV_RST;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset registers, extremes, saturation, clear
    put(REQ_READ, '0, 1'b0, 12'd0);
    put(REQ_ROW, 32'h7FFF_FFFF, 1'b1, '0);
    put(REQ_ROW, 32'h8000_0000, 1'b1, '0);
    put(REQ_ROW, 32'h0100_0000, 1'b0, '0);
    put(REQ_NONZERO, 32'h7FFF_FFFF, 1'b0, 12'd0);
    put(REQ_NONZERO, 32'h8000_0000, 1'b0, 12'd4095);
    put(REQ_ROW, 32'h7FFF_FFFF, 1'b0, '0);
    repeat (3) put(REQ_NONZERO, 32'h7FFF_FFFF, 1'b0, 12'd5);
    put(REQ_ROW, 32'h8000_0000, 1'b0, '0);
    repeat (3) put(REQ_NONZERO, 32'h7FFF_FFFF, 1'b0, 12'd6);
    put(REQ_NONZERO, 32'h8000_0000, 1'b0, 12'd0);
    put(REQ_READ, '0, 1'b0, 12'd0);
    put(REQ_READ, '0, 1'b0, 12'd4095);
    put(REQ_READ, '0, 1'b0, 12'd5);
    put(REQ_READ, '0, 1'b0, 12'd6);
    put(REQ_READ, '0, 1'b0, 12'd1);
    put(REQ_CLEAR, '0, 1'b0, '0);
    put(REQ_READ, '0, 1'b0, 12'd5);
    put(REQ_ROW, 32'hFFFF_FFFF, 1'b1, '0);
    put(REQ_READ, '0, 1'b0, 12'd4095);
    queue_random(250);

    run_phase(32'd16,   32'h0026_6666, 32'h1000_0000, 0,  300);
    run_phase(32'd4096, $urandom(),    $urandom(),    80, 250);
    run_phase(32'd1,    32'h7FFF_FFFF, 32'hFFFF_FFFF, 9,  150);
    run_phase(32'd0,    32'h8000_0000, 32'h0000_0000, 0,  60);
    run_phase(32'd8191, pick_q824(),   $urandom(),    9,  250);
    run_phase(32'd300,  $urandom(),    32'h00DA_740D, 80, 300);
    run_phase(32'd4096, 32'h0000_0000, 32'h0010_0000, 0,  100);

    wait_idle();
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/prspmv_pkg.sv
design/prspmv_ram.sv
design/prspmv_cfg.sv
design/prspmv_core.sv
design/pagerank_sparse_scatter_spmv.sv
design/prspmv_chk.sv
sim/pagerank_sparse_scatter_spmv_tb.sv
